// ===== hdl/single_server_queue_sim_tick_assert.svh =====
`ifndef SINGLE_SERVER_QUEUE_SIM_TICK_ASSERT_SVH
`define SINGLE_SERVER_QUEUE_SIM_TICK_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SSQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SSQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ssq_pkg.sv =====
package ssq_pkg;

  // default sizing
  localparam int DEF_FIFO_DEPTH   = 64;
  localparam int DEF_TIME_BITS    = 16;
  localparam int DEF_SERVICE_BITS = 8;

  // fixed field widths
  localparam int ID_W    = 16;
  localparam int TOTAL_W = 16;
  localparam int WSUM_W  = 32;
  localparam int PCT_W   = 7;

  // register port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam int REG_IDX_W = APB_AW - 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ARRIVAL_PCT = 1'b0
  } reg_idx_t;

  localparam logic [PCT_W-1:0] PCT_RESET = PCT_W'(50);

endpackage

// ===== hdl/ssq_ram.sv =====
module ssq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read-first: a same-cycle write is not seen by the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/single_server_queue_sim_tick.sv =====
// Single-server FIFO queue simulator, one simulated tick per input word.
//
// Input channel (in_valid / in_stall): each word is one tick carrying the
// arrival draw, the service time of a job arriving this tick, and a
// last-tick mark. Result channel (out_valid / out_stall): exactly one word
// per tick with arrival, start, server and queue status plus running totals.
// Arrival threshold is set through the APB register at byte address 0;
// write it only while the block is idle.
//
// The result word is registered at the edge that accepts the tick, so it
// shows in the next cycle. Throughput: one tick per clock while in_stall
// is low. The whole tick is settled combinationally between the input
// ports and the result register; the waiting-job ring sits in a
// registered-read RAM whose read address is steered to the next head ahead
// of time, with a bypass for a word written to that same slot.
//
// Reset (rst_n low, synchronous): queue empty, server idle, tick 0, next
// job id 1, totals 0, threshold 50. No clearing pass is needed.
// While the receiver stalls with a result pending, in_stall goes high and
// the held result word stays unchanged until it is taken.
module single_server_queue_sim_tick
  import ssq_pkg::*;
#(
  parameter int FIFO_DEPTH   = DEF_FIFO_DEPTH,
  parameter int TIME_BITS    = DEF_TIME_BITS,
  parameter int SERVICE_BITS = DEF_SERVICE_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [APB_AW-1:0]                   paddr,
  input  logic [APB_DW-1:0]                   pwdata,
  output logic [APB_DW-1:0]                   prdata,
  output logic                                pready,
  // tick input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [PCT_W-1:0]                    in_random_draw,
  input  logic [SERVICE_BITS-1:0]             in_service_time,
  input  logic                                in_last_tick,
  // result output
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_arrival_accepted,
  output logic                                out_arrival_dropped,
  output logic [ID_W-1:0]                     out_arrived_job_id,
  output logic                                out_start_valid,
  output logic [ID_W-1:0]                     out_start_job_id,
  output logic [TIME_BITS-1:0]                out_start_wait,
  output logic [SERVICE_BITS-1:0]             out_busy_left,
  output logic [$clog2(FIFO_DEPTH+1)-1:0]     out_queue_count,
  output logic [TOTAL_W-1:0]                  out_arrived_total,
  output logic [TOTAL_W-1:0]                  out_started_total,
  output logic [WSUM_W-1:0]                   out_wait_total,
  output logic                                out_run_done
);

  localparam int PTR_W  = $clog2(FIFO_DEPTH);
  localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam int WORD_W = ID_W + TIME_BITS + SERVICE_BITS;

  localparam logic [PTR_W-1:0]   PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0]   CNT_FULL = CNT_W'(FIFO_DEPTH);
  localparam logic [ID_W-1:0]    ID_ONE   = ID_W'(1);
  localparam logic [TOTAL_W-1:0] TOT_MAX  = '1;
  localparam logic [WSUM_W-1:0]  WSUM_MAX = '1;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    ring_next = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  // ---------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------
  logic [PCT_W-1:0] pct_r;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[APB_AW-1:2] == REG_ARRIVAL_PCT);
  assign prdata  = reg_sel ? APB_DW'(pct_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pct_r <= PCT_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      pct_r <= pwdata[PCT_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Simulation state
  // ---------------------------------------------------------------------
  logic [PTR_W-1:0]        head_r, head_nxt;
  logic [PTR_W-1:0]        tail_r, tail_nxt;
  logic [CNT_W-1:0]        occ_r, occ_nxt;
  logic [SERVICE_BITS-1:0] rem_r, rem_nxt;
  logic [TIME_BITS-1:0]    tick_r, tick_nxt;
  logic [ID_W-1:0]         next_id_r, next_id_nxt;
  logic [TOTAL_W-1:0]      arr_tot_r, arr_tot_nxt;
  logic [TOTAL_W-1:0]      start_tot_r, start_tot_nxt;
  logic [WSUM_W-1:0]       wsum_r, wsum_nxt;

  // head-slot bypass for a write that hit the slot being read
  logic                    byp_r, byp_nxt;
  logic [WORD_W-1:0]       byp_word_r;

  logic                    accept;
  logic                    arrive, full, push, pop;
  logic [ID_W-1:0]         id_inc;
  logic [CNT_W-1:0]        occ_push;
  logic [SERVICE_BITS-1:0] rem_dec;
  logic [WORD_W-1:0]       wr_word, ram_rdata, head_word;
  logic                    from_input;
  logic [ID_W-1:0]         head_id;
  logic [TIME_BITS-1:0]    head_arr, wait_ticks;
  logic [SERVICE_BITS-1:0] head_serv;
  logic [WSUM_W:0]         wsum_add;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // arrival and push
  assign arrive   = (in_random_draw <= pct_r);
  assign full     = (occ_r == CNT_FULL);
  assign push     = arrive && !full;
  assign id_inc   = next_id_r + ID_ONE;
  assign occ_push = occ_r + CNT_W'(push);
  assign wr_word  = {next_id_r, tick_r, in_service_time};

  // server countdown, then pop when idle
  assign rem_dec  = (rem_r != '0) ? rem_r - SERVICE_BITS'(1) : '0;
  assign pop      = (rem_dec == '0) && (occ_push != '0);

  // empty queue: the only candidate is the job arriving this tick
  assign head_word  = byp_r ? byp_word_r : ram_rdata;
  assign from_input = (occ_r == '0);
  assign head_id    = from_input ? next_id_r : head_word[WORD_W-1 -: ID_W];
  assign head_arr   = from_input ? tick_r : head_word[SERVICE_BITS +: TIME_BITS];
  assign head_serv  = from_input ? in_service_time : head_word[SERVICE_BITS-1:0];
  assign wait_ticks = tick_r - head_arr;
  assign wsum_add   = {1'b0, wsum_r} + (WSUM_W+1)'(wait_ticks);

  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    occ_nxt       = occ_r;
    rem_nxt       = rem_r;
    tick_nxt      = tick_r;
    next_id_nxt   = next_id_r;
    arr_tot_nxt   = arr_tot_r;
    start_tot_nxt = start_tot_r;
    wsum_nxt      = wsum_r;
    if (accept) begin
      tick_nxt = tick_r + TIME_BITS'(1);
      if (arrive) begin
        next_id_nxt = (id_inc == '0) ? ID_ONE : id_inc;
        if (arr_tot_r != TOT_MAX) begin
          arr_tot_nxt = arr_tot_r + TOTAL_W'(1);
        end
      end
      if (push) begin
        tail_nxt = ring_next(tail_r);
      end
      if (pop) begin
        head_nxt = ring_next(head_r);
        occ_nxt  = occ_push - CNT_W'(1);
        rem_nxt  = head_serv;
        if (start_tot_r != TOT_MAX) begin
          start_tot_nxt = start_tot_r + TOTAL_W'(1);
        end
        wsum_nxt = wsum_add[WSUM_W] ? WSUM_MAX : wsum_add[WSUM_W-1:0];
      end else begin
        occ_nxt = occ_push;
        rem_nxt = rem_dec;
      end
    end
  end

  // read address tracks the head for the next tick
  assign byp_nxt = accept && push && (tail_r == head_nxt);

  ssq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (FIFO_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (accept && push),
    .waddr (tail_r),
    .wdata (wr_word),
    .raddr (head_nxt),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      rem_r       <= '0;
      tick_r      <= '0;
      next_id_r   <= ID_ONE;
      arr_tot_r   <= '0;
      start_tot_r <= '0;
      wsum_r      <= '0;
      byp_r       <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      occ_r       <= occ_nxt;
      rem_r       <= rem_nxt;
      tick_r      <= tick_nxt;
      next_id_r   <= next_id_nxt;
      arr_tot_r   <= arr_tot_nxt;
      start_tot_r <= start_tot_nxt;
      wsum_r      <= wsum_nxt;
      byp_r       <= byp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && push) begin
      byp_word_r <= wr_word;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_arrival_accepted <= push;
      out_arrival_dropped  <= arrive && full;
      out_arrived_job_id   <= arrive ? next_id_r : '0;
      out_start_valid      <= pop;
      out_start_job_id     <= pop ? head_id : '0;
      out_start_wait       <= pop ? wait_ticks : '0;
      out_busy_left        <= rem_nxt;
      out_queue_count      <= occ_nxt;
      out_arrived_total    <= arr_tot_nxt;
      out_started_total    <= start_tot_nxt;
      out_wait_total       <= wsum_nxt;
      out_run_done         <= in_last_tick;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hdl/ssq_checker.sv =====
`include "single_server_queue_sim_tick_assert.svh"

module ssq_checker
  import ssq_pkg::*;
#(
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 out_arrival_accepted,
  input logic                 out_arrival_dropped,
  input logic [ID_W-1:0]      out_arrived_job_id,
  input logic                 out_start_valid,
  input logic [ID_W-1:0]      out_start_job_id,
  input logic [TIME_BITS-1:0] out_start_wait
);

  // a stalled result word is held
  `SSQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_arrived_job_id) && $stable(out_start_job_id), "stalled result word changed")

  // input backpressure only comes from a stalled pending result
  `SSQ_ASSERT_NOW(a_stall_src, in_stall, out_valid && out_stall, "input stalled without output backpressure")

  // no start means zero id and wait
  `SSQ_ASSERT_NOW(a_no_start, out_valid && !out_start_valid, out_start_job_id == '0 && out_start_wait == '0, "start fields set without a start")

  // a queued job is not also dropped and never has id zero
  `SSQ_ASSERT_NOW(a_acc_id, out_valid && out_arrival_accepted, !out_arrival_dropped && out_arrived_job_id != '0, "bad accepted arrival")

  // no arrival means id zero
  `SSQ_ASSERT_NOW(a_no_arr, out_valid && !out_arrival_accepted && !out_arrival_dropped, out_arrived_job_id == '0, "arrival id without arrival")

endmodule

bind single_server_queue_sim_tick ssq_checker #(
  .TIME_BITS (TIME_BITS)
) u_ssq_checker (.*);
